// File: rtl/core/svpwm_pkg.sv
// Shared types, constants and helper functions for the space vector PWM duty block.
package svpwm_pkg;

    typedef logic [2:0] sector_t;

    // Sector codes: sector number minus one
    localparam sector_t SEC_ONE   = 3'd0;
    localparam sector_t SEC_TWO   = 3'd1;
    localparam sector_t SEC_THREE = 3'd2;
    localparam sector_t SEC_FOUR  = 3'd3;
    localparam sector_t SEC_FIVE  = 3'd4;
    localparam sector_t SEC_SIX   = 3'd5;

    // Configuration register indexes
    localparam logic REG_PWM_PERIOD   = 1'b0;
    localparam logic REG_PERIOD_ROOT3 = 1'b1;

    localparam logic [14:0] PWM_PERIOD_RESET   = 15'd4096;
    localparam logic [15:0] PERIOD_ROOT3_RESET = 16'd14189;

    localparam int unsigned HALF_SHIFT    = 1;
    localparam int unsigned QUARTER_SHIFT = 17;
    localparam int unsigned BASE_SHIFT    = 18;

    localparam int unsigned WIDE_W = 35;
    localparam int unsigned TIME_W = 20;
    localparam int unsigned OFFS_W = 18;

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [TIME_W-1:0] time_t;
    typedef logic signed [OFFS_W-1:0] offs_t;

    // Signed divide by 2^k, truncating toward zero
    function automatic wide_t div_pow2(input wide_t n, input int unsigned k);
        wide_t bias;
        bias = (wide_t'(1) <<< k) - wide_t'(1);
        return (n + (n[WIDE_W-1] ? bias : wide_t'(0))) >>> k;
    endfunction

    function automatic logic [15:0] clamp16(input time_t t);
        logic [15:0] r;
        if (t < 0)
        begin
            r = 16'd0;
        end
        else if (t > time_t'(65535))
        begin
            r = 16'hFFFF;
        end
        else
        begin
            r = t[15:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/space_vector_pwm_duty.sv
// Space vector PWM duty block: alpha/beta command to sector, phase counts and sorted duties.
//
// Input stream s_*: one word per voltage command, v_alpha and v_beta (signed 16 bit).
// Output stream m_*: one word per command with the sector (0..5, sector number minus
// one), the three phase compare counts clamped to 0..65535, and the low, mid and high
// duties sorted for the sector (low 16 bits of the phase times).
// Configuration: cfg_we writes cfg_data into register cfg_index (0: pwm_period,
// 1: period_root3); write only while no word is in flight.
// Timing: a five-stage pipeline (input register, multiply, X/Y/Z, sector and scaled
// terms, phase times and result register); one word is taken every cycle while the
// output is drained.
// Stall: when m_tready is low with a result held, every stage freezes and s_tready
// drops in the same cycle; nothing is lost or repeated.
// Reset: rst_n clears all stage valid flags and returns pwm_period to 4096 and
// period_root3 to 14189.
module space_vector_pwm_duty
    import svpwm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [15:0] v_alpha, [31:16] v_beta
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [2:0] sector, [18:3] count_a, [34:19] count_b,
                                    // [50:35] count_c, [66:51] duty_low,
                                    // [82:67] duty_mid, [98:83] duty_high, rest zero
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);

    logic [14:0] pwm_period_reg;
    logic [15:0] period_root3_reg;

    logic        advance;
    logic [4:0]  valid_reg;

    logic signed [15:0] va_reg, vb_reg;
    logic signed [32:0] ua_reg;
    logic signed [33:0] ub_reg;
    wide_t              x_reg, y_reg, z_reg;
    sector_t            sec_reg;
    time_t              q0_reg;
    offs_t              qx_reg, qy_reg, qz_reg;
    logic [98:0]        res_reg;

    logic signed [32:0] ua_next;
    logic signed [33:0] ub_next;
    logic signed [31:0] vb_per;
    wide_t              y_next, z_next;
    sector_t            sec_next;
    wide_t              diff, diff_q, x_q, y_q, z_q;
    time_t              base, ta, tb, tc, lo, mid, hi;
    logic [98:0]        res_next;

    assign advance  = !valid_reg[4] || m_tready;
    assign s_tready = advance;
    assign m_tvalid = valid_reg[4];
    assign m_tdata  = {5'd0, res_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg   <= PWM_PERIOD_RESET;
            period_root3_reg <= PERIOD_ROOT3_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PWM_PERIOD:   pwm_period_reg   <= cfg_data[14:0];
                REG_PERIOD_ROOT3: period_root3_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[3:0], s_tvalid};
        end
    end

    // Products
    always_comb
    begin
        ua_next = 33'(va_reg) * 33'($signed({1'b0, period_root3_reg}));
        vb_per  = 32'(vb_reg) * 32'($signed({1'b0, pwm_period_reg}));
        ub_next = -(34'(vb_per) <<< 1);
    end

    // Y and Z; X is ub itself, copied in the register stage
    always_comb
    begin
        y_next = div_pow2(wide_t'(ub_reg) + wide_t'(ua_reg), HALF_SHIFT);
        z_next = div_pow2(wide_t'(ub_reg) - wide_t'(ua_reg), HALF_SHIFT);
    end

    // Sector and scaled terms
    always_comb
    begin
        if (y_reg < 0)
        begin
            if (z_reg < 0)
                sec_next = SEC_FIVE;
            else if (x_reg <= 0)
                sec_next = SEC_FOUR;
            else
                sec_next = SEC_THREE;
        end
        else
        begin
            if (z_reg >= 0)
                sec_next = SEC_TWO;
            else if (x_reg <= 0)
                sec_next = SEC_SIX;
            else
                sec_next = SEC_ONE;
        end

        case (sec_next)
            SEC_FIVE, SEC_TWO: diff = y_reg - z_reg;
            SEC_FOUR, SEC_ONE: diff = x_reg - z_reg;
            default:           diff = y_reg - x_reg;
        endcase

        diff_q = div_pow2(diff, BASE_SHIFT);
        x_q    = div_pow2(x_reg, QUARTER_SHIFT);
        y_q    = div_pow2(y_reg, QUARTER_SHIFT);
        z_q    = div_pow2(z_reg, QUARTER_SHIFT);
    end

    // Phase times and sorting
    always_comb
    begin
        base = $signed({7'd0, pwm_period_reg[14:2]});
        ta   = base + q0_reg;
        case (sec_reg)
            SEC_FIVE, SEC_TWO:
            begin
                tb = ta + time_t'(qz_reg);
                tc = ta - time_t'(qy_reg);
            end
            SEC_FOUR, SEC_ONE:
            begin
                tb = ta + time_t'(qz_reg);
                tc = tb - time_t'(qx_reg);
            end
            default:
            begin
                tc = ta - time_t'(qy_reg);
                tb = tc + time_t'(qx_reg);
            end
        endcase

        case (sec_reg)
            SEC_FIVE:  begin lo = tc; mid = ta; hi = tb; end
            SEC_FOUR:  begin lo = tc; mid = tb; hi = ta; end
            SEC_THREE: begin lo = tb; mid = tc; hi = ta; end
            SEC_TWO:   begin lo = tb; mid = ta; hi = tc; end
            SEC_SIX:   begin lo = ta; mid = tc; hi = tb; end
            default:   begin lo = ta; mid = tb; hi = tc; end
        endcase

        res_next = {hi[15:0], mid[15:0], lo[15:0],
                    clamp16(tc), clamp16(tb), clamp16(ta), sec_reg};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            va_reg  <= $signed(s_tdata[15:0]);
            vb_reg  <= $signed(s_tdata[31:16]);
            ua_reg  <= ua_next;
            ub_reg  <= ub_next;
            x_reg   <= wide_t'(ub_reg);
            y_reg   <= y_next;
            z_reg   <= z_next;
            sec_reg <= sec_next;
            q0_reg  <= diff_q[TIME_W-1:0];
            qx_reg  <= x_q[OFFS_W-1:0];
            qy_reg  <= y_q[OFFS_W-1:0];
            qz_reg  <= z_q[OFFS_W-1:0];
            res_reg <= res_next;
        end
    end

endmodule

// File: tb/tb_space_vector_pwm_duty.sv
// Self-checking testbench for the space vector PWM duty block: predicted sectors, counts and duties.
module tb_space_vector_pwm_duty;
    import svpwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASES      = 10;
    localparam int unsigned RAND_ITEMS  = 113;
    localparam int unsigned LONG_HOLD   = 120;
    localparam int unsigned HOLD_AT     = 300;

    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] duty_high;
        logic [15:0] duty_mid;
        logic [15:0] duty_low;
        logic [15:0] count_c;
        logic [15:0] count_b;
        logic [15:0] count_a;
        sector_t     sector;
    } duty_word_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic         cfg_index = REG_PWM_PERIOD;
    logic [15:0]  cfg_data = '0;

    logic [31:0]  pending_cmds[$];
    duty_word_t   expected_duties[$];

    logic [14:0]  cfg_period = PWM_PERIOD_RESET;
    logic [15:0]  cfg_root3 = PERIOD_ROOT3_RESET;
    logic         tx_idle_on = 1'b1;
    logic         rx_idle_on = 1'b1;

    int unsigned  accepted_words = 0;
    int unsigned  tx_gap = 0;
    int unsigned  rx_stall_left = 0;
    int unsigned  rx_hold_left = 0;
    logic         long_hold_done = 1'b0;
    int unsigned  fault_count = 0;
    int unsigned  cycle_count = 0;

    space_vector_pwm_duty dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [15:0] clamp_count(input longint t);
        logic [15:0] r;
        if (t < 0)
        begin
            r = 16'd0;
        end
        else if (t > 65535)
        begin
            r = 16'hFFFF;
        end
        else
        begin
            r = t[15:0];
        end
        return r;
    endfunction

    // Phase times and sector for one alpha/beta command
    function automatic duty_word_t svm_duties(input logic signed [15:0] va,
                                              input logic signed [15:0] vb,
                                              input logic [14:0] per,
                                              input logic [15:0] r3);
        duty_word_t r;
        longint ua, ub, x, y, z, base, ta, tb, tc, lo, mid, hi;
        sector_t sec;
        ua = longint'(va) * longint'(r3);
        ub = -(longint'(vb) * longint'(per)) * 2;
        x = ub;
        y = (ub + ua) / 2;
        z = (ub - ua) / 2;
        base = longint'(per) / 4;
        if (y < 0)
        begin
            if (z < 0)
            begin
                sec = SEC_FIVE;
                ta = base + (y - z) / 262144;
                tb = ta + z / 131072;
                tc = ta - y / 131072;
                lo = tc; mid = ta; hi = tb;
            end
            else if (x <= 0)
            begin
                sec = SEC_FOUR;
                ta = base + (x - z) / 262144;
                tb = ta + z / 131072;
                tc = tb - x / 131072;
                lo = tc; mid = tb; hi = ta;
            end
            else
            begin
                sec = SEC_THREE;
                ta = base + (y - x) / 262144;
                tc = ta - y / 131072;
                tb = tc + x / 131072;
                lo = tb; mid = tc; hi = ta;
            end
        end
        else
        begin
            if (z >= 0)
            begin
                sec = SEC_TWO;
                ta = base + (y - z) / 262144;
                tb = ta + z / 131072;
                tc = ta - y / 131072;
                lo = tb; mid = ta; hi = tc;
            end
            else if (x <= 0)
            begin
                sec = SEC_SIX;
                ta = base + (y - x) / 262144;
                tc = ta - y / 131072;
                tb = tc + x / 131072;
                lo = ta; mid = tc; hi = tb;
            end
            else
            begin
                sec = SEC_ONE;
                ta = base + (x - z) / 262144;
                tb = ta + z / 131072;
                tc = tb - x / 131072;
                lo = ta; mid = tb; hi = tc;
            end
        end
        r.pad       = '0;
        r.sector    = sec;
        r.count_a   = clamp_count(ta);
        r.count_b   = clamp_count(tb);
        r.count_c   = clamp_count(tc);
        r.duty_low  = lo[15:0];
        r.duty_mid  = mid[15:0];
        r.duty_high = hi[15:0];
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [15:0] pick_extreme();
        logic [15:0] vals[5];
        vals = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
        return vals[$urandom_range(0, 4)];
    endfunction

    // Mostly uniform commands, with extremes, small values and axis/diagonal cases
    function automatic logic [31:0] random_cmd();
        logic [15:0] va, vb;
        int unsigned r;
        va = 16'($urandom);
        vb = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r inside {[55:64]})
        begin
            va = pick_extreme();
            vb = pick_extreme();
        end
        else if (r inside {[65:74]})
        begin
            va = 16'($signed($urandom_range(0, 511)) - 256);
            vb = 16'($signed($urandom_range(0, 511)) - 256);
        end
        else if (r inside {[75:84]})
        begin
            vb = va;
        end
        else if (r inside {[85:89]})
        begin
            vb = -va;
        end
        else if (r inside {[90:94]})
        begin
            vb = '0;
        end
        else if (r inside {[95:99]})
        begin
            va = '0;
        end
        return {vb, va};
    endfunction

    // Sender: one word offered at a time, random gaps after each accepted word while tx_idle_on is set
    always @(posedge clk or negedge rst_n)
    begin : drive_input
        logic offer;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_gap = 0;
        end
        else
        begin
            offer = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                expected_duties.push_back(svm_duties(s_tdata[15:0], s_tdata[31:16],
                                                     cfg_period, cfg_root3));
                accepted_words++;
                offer = 1'b0;
                tx_gap = tx_idle_on ? pick_gap() : 0;
            end
            if (!offer)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                end
                else if (pending_cmds.size() > 0)
                begin
                    s_tdata <= pending_cmds.pop_front();
                    offer = 1'b1;
                end
            end
            s_tvalid <= offer;
        end
    end

    // Receiver: random stalls while rx_idle_on is set, plus one long hold-off to back the pipe up
    always @(posedge clk or negedge rst_n)
    begin : drive_ready
        logic ready;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (!long_hold_done && accepted_words >= HOLD_AT)
            begin
                rx_hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                ready = 1'b0;
            end
            else if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                ready = 1'b0;
            end
            else
            begin
                ready = 1'b1;
                if (rx_idle_on && $urandom_range(0, 3) == 0)
                begin
                    rx_stall_left = pick_gap();
                end
            end
            m_tready <= ready;
        end
    end

    always @(posedge clk)
    begin : check_output
        duty_word_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_duties.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                begin
                    $display("unexpected word %h", m_tdata);
                end
            end
            else
            begin
                want = expected_duties.pop_front();
                if (got !== want)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("exp sec %0d a %0d b %0d c %0d lo %0d mid %0d hi %0d pad %h",
                                 want.sector, want.count_a, want.count_b, want.count_c,
                                 want.duty_low, want.duty_mid, want.duty_high, want.pad);
                        $display("got sec %0d a %0d b %0d c %0d lo %0d mid %0d hi %0d pad %h",
                                 got.sector, got.count_a, got.count_b, got.count_c,
                                 got.duty_low, got.duty_mid, got.duty_high, got.pad);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PWM_PERIOD)
        begin
            cfg_period = val[14:0];
        end
        else
        begin
            cfg_root3 = val;
        end
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_duties.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [14:0] periods[PHASES];
        logic [15:0] roots[PHASES];
        logic [15:0] dir_a[22];
        logic [15:0] dir_b[22];
        periods = '{PWM_PERIOD_RESET, 15'd2, 15'd32767, 15'd0, 15'd1, 15'd4096,
                    15'd0, 15'd0, 15'd0, PWM_PERIOD_RESET};
        roots   = '{PERIOD_ROOT3_RESET, 16'd0, 16'd65535, 16'd65535, 16'd1, 16'd8192,
                    16'd0, 16'd0, 16'd0, PERIOD_ROOT3_RESET};
        dir_a = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                  16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF,
                  16'h8000, 16'h4000, 16'hC000, 16'h2000, 16'd100, 16'hFF9C, 16'h5555,
                  16'hAAAA};
        dir_b = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
                  16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000,
                  16'h0000, 16'h0000, 16'h4000, 16'hE000, 16'hFFCE, 16'd50, 16'hAAAA,
                  16'h5555};
        for (int i = 6; i < 9; i++)
        begin
            periods[i] = 15'($urandom_range(2, 32767));
            roots[i]   = 16'($urandom);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            if (p > 0)
            begin
                write_reg(REG_PWM_PERIOD, {1'b0, periods[p]});
                write_reg(REG_PERIOD_ROOT3, roots[p]);
            end
            tx_idle_on = (p % 4) != 1;
            rx_idle_on = (p % 4) != 2;
            if (p == 0 || p == 5)
            begin
                for (int i = 0; i < 22; i++)
                begin
                    pending_cmds.push_back({dir_b[i], dir_a[i]});
                end
            end
            for (int i = 0; i < RAND_ITEMS; i++)
            begin
                pending_cmds.push_back(random_cmd());
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fault_count == 0 && expected_duties.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
